>>> rtl/dre_pkg.sv
// Shared types and constants of the delta Rice byte encoder.
`default_nettype none

package dre_pkg;

    // Field widths and coding constants.
    localparam int SampleBits = 8;
    localparam int ByteBits   = 8;
    localparam int KBits      = 4;
    localparam int HeaderBits = 32;
    localparam int QuotMax    = 15;
    localparam int MaxBytes   = 8;
    localparam int AccBits    = 64;
    localparam int PendBits   = 7;

    typedef logic [SampleBits-1:0] t_sample;
    typedef logic [ByteBits-1:0]   t_byte;
    typedef logic [KBits-1:0]      t_rice_k;
    typedef logic [HeaderBits-1:0] t_cfg_data;

    // Configuration register indexes.
    typedef enum logic [0:0] {
        CfgRiceK        = 1'b0,
        CfgStreamLength = 1'b1
    } t_cfg_idx;

endpackage

`default_nettype wire

>>> rtl/dre_in_if.sv
// Input channel of the encoder: one sample and its end-of-stream flag.
`default_nettype none

interface dre_in_if;
    logic              valid;
    logic              ready;
    dre_pkg::t_sample  sample;
    logic              final_sample;

    modport source (output valid, output sample, output final_sample, input ready);
    modport sink   (input valid, input sample, input final_sample, output ready);
endinterface

`default_nettype wire

>>> rtl/dre_out_if.sv
// Output channel of the encoder: one coded byte with its marker flags.
`default_nettype none

interface dre_out_if;
    logic            valid;
    logic            ready;
    dre_pkg::t_byte  out_byte;
    logic            run_last;
    logic            stream_end;

    modport source (output valid, output out_byte, output run_last, output stream_end,
                    input ready);
    modport sink   (input valid, input out_byte, input run_last, input stream_end,
                    output ready);
endinterface

`default_nettype wire

>>> rtl/delta_rice_byte_encoder.sv
// Delta-predicted Rice coder that packs the code into bytes, MSB first.
//
// Usage: samples enter on i_in (valid/ready); coded bytes leave on o_out
// (valid/ready). Before the first sample of a stream four header bytes carry
// the stream_length register, most significant byte first. run_last marks the
// last byte caused by one input transaction and stream_end the final byte of
// a stream. A sample that completes no byte produces no output transaction.
// Registers are written through i_cfg_we / i_cfg_idx / i_cfg_data; the user
// must write them only while idle, which the block itself does not enforce.
// The first byte of a sample reaches o_out behind the bundle and the output
// register. A sample is coded combinationally into a byte bundle register
// that holds at most eight bytes; the output register then drains one byte
// per cycle while the receiver is ready.
// When the receiver stalls, the output register holds its byte and the bundle
// holds the rest; a new sample is accepted as soon as the bundle is empty or
// its final byte moves to the output register in that cycle.
// Reset (synchronous, active low) clears the registers, the predictor, the
// pending bits, the header flag and all valid state.
`default_nettype none

module delta_rice_byte_encoder (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_cfg_we,
    input  dre_pkg::t_cfg_idx   i_cfg_idx,
    input  dre_pkg::t_cfg_data  i_cfg_data,
    dre_in_if.sink              i_in,
    dre_out_if.source           o_out
);
    import dre_pkg::*;

    // Configuration and stream state.
    t_rice_k              r_rice_k;
    t_cfg_data            r_stream_len;
    t_sample              r_prev;
    logic [PendBits-1:0]  r_pend_bits;
    logic [2:0]           r_pend_cnt;
    logic                 r_hdr_sent;

    // Byte bundle awaiting transfer to the output register.
    logic [AccBits-1:0]   r_bundle;
    logic [3:0]           r_cnt;
    logic                 r_fin;

    // Output register.
    logic                 r_ov;
    t_byte                r_ob;
    logic                 r_orl;
    logic                 r_ose;

    logic                 w_accept;
    logic                 w_load;
    logic [8:0]           w_diff_pos;
    logic [8:0]           w_diff_neg;
    logic [8:0]           w_mapped;
    logic [8:0]           w_qfull;
    logic [3:0]           w_q;
    logic [15:0]          w_ones;
    logic [15:0]          w_unary;
    logic [15:0]          w_rem_mask;
    logic [15:0]          w_rem;
    logic [31:0]          w_code;
    logic [5:0]           w_len;
    logic [AccBits-1:0]   w_acc0;
    logic [AccBits-1:0]   w_acc1;
    logic [AccBits-1:0]   w_acc;
    logic [6:0]           w_nbits;
    logic [AccBits-1:0]   w_aligned;
    logic [2:0]           w_tail;
    logic [3:0]           w_nbytes;
    logic [PendBits-1:0]  w_tail_mask;

    // Handshakes: the bundle takes a new sample when it is empty or empties this cycle.
    assign w_load   = (r_cnt != 4'd0) && (!r_ov || o_out.ready);
    assign i_in.ready = (r_cnt == 4'd0) || ((r_cnt == 4'd1) && w_load);
    assign w_accept = i_in.valid && i_in.ready;

    // Zig-zag mapped delta and the saturated quotient.
    always_comb begin
        w_diff_pos = {1'b0, i_in.sample} - {1'b0, r_prev};
        w_diff_neg = {1'b0, r_prev} - {1'b0, i_in.sample};
        if (i_in.sample >= r_prev) begin
            w_mapped = {w_diff_pos[7:0], 1'b0};
        end else begin
            w_mapped = {w_diff_neg[7:0], 1'b0} - 9'd1;
        end
        w_qfull = w_mapped >> r_rice_k;
        w_q     = (w_qfull > 9'(QuotMax)) ? 4'(QuotMax) : w_qfull[3:0];
    end

    // Code word: q ones, a zero, then rice_k remainder bits.
    always_comb begin
        w_ones     = 16'((17'd1 << w_q) - 17'd1);
        w_unary    = {w_ones[14:0], 1'b0};
        w_rem_mask = 16'((17'd1 << r_rice_k) - 17'd1);
        w_rem      = {7'd0, w_mapped} & w_rem_mask;
        w_code     = ({16'd0, w_unary} << r_rice_k) | {16'd0, w_rem};
        w_len      = 6'(w_q) + 6'd1 + 6'(r_rice_k);
    end

    // Bit accumulator: pending bits, optional header, then the code word.
    always_comb begin
        w_acc0      = {{(AccBits-PendBits){1'b0}}, r_pend_bits};
        w_acc1      = r_hdr_sent ? w_acc0
                                 : ((w_acc0 << HeaderBits) | {32'd0, r_stream_len});
        w_acc       = (w_acc1 << w_len) | {32'd0, w_code};
        w_nbits     = 7'(r_pend_cnt) + (r_hdr_sent ? 7'd0 : 7'(HeaderBits)) + 7'(w_len);
        w_aligned   = w_acc << (7'd64 - w_nbits);
        w_tail      = w_nbits[2:0];
        w_nbytes    = w_nbits[6:3] + {3'd0, i_in.final_sample && (w_tail != 3'd0)};
        w_tail_mask = 7'((8'd1 << w_tail) - 8'd1);
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rice_k     <= '0;
            r_stream_len <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CfgRiceK:        r_rice_k     <= i_cfg_data[KBits-1:0];
                CfgStreamLength: r_stream_len <= i_cfg_data;
                default:         r_rice_k     <= r_rice_k;
            endcase
        end
    end

    // Stream state, updated on each accepted transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev      <= '0;
            r_pend_bits <= '0;
            r_pend_cnt  <= '0;
            r_hdr_sent  <= 1'b0;
        end else if (w_accept) begin
            if (i_in.final_sample) begin
                r_prev      <= '0;
                r_pend_bits <= '0;
                r_pend_cnt  <= '0;
                r_hdr_sent  <= 1'b0;
            end else begin
                r_prev      <= i_in.sample;
                r_pend_bits <= w_acc[PendBits-1:0] & w_tail_mask;
                r_pend_cnt  <= w_tail;
                r_hdr_sent  <= 1'b1;
            end
        end
    end

    // Byte bundle: loaded on accept, shifted one byte per transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (w_accept) begin
            r_cnt <= w_nbytes;
        end else if (w_load) begin
            r_cnt <= r_cnt - 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_bundle <= w_aligned;
            r_fin    <= i_in.final_sample;
        end else if (w_load) begin
            r_bundle <= r_bundle << ByteBits;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_load) begin
            r_ov <= 1'b1;
        end else if (o_out.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_ob  <= r_bundle[AccBits-1 -: ByteBits];
            r_orl <= (r_cnt == 4'd1);
            r_ose <= (r_cnt == 4'd1) && r_fin;
        end
    end

    assign o_out.valid      = r_ov;
    assign o_out.out_byte   = r_ob;
    assign o_out.run_last   = r_orl;
    assign o_out.stream_end = r_ose;

    // A bundle never holds more than eight bytes.
    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_cnt <= 4'(MaxBytes))
        else $error("byte bundle overfilled");

    // No new sample is taken while more than one bundled byte is left.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt > 4'd1) |-> !i_in.ready)
        else $error("sample accepted over a busy bundle");

    // A final sample clears the stream state for the next stream.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_in.final_sample) |=> (!r_hdr_sent && r_pend_cnt == 3'd0
                                             && r_prev == '0))
        else $error("stream state not cleared after final sample");

    // A final sample always yields at least one byte.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_in.final_sample) |=> (r_cnt != 4'd0 && r_fin))
        else $error("final sample produced no byte");

    // The header is sent only once per stream.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !i_in.final_sample) |=> r_hdr_sent)
        else $error("header flag not set after a sample");

endmodule

`default_nettype wire
